### hw/rtl/tiled_block_cache_controller_assert.svh
// assertion macros for the tiled block cache controller checker
// expects clk and arst_n to be visible where a macro is used
`ifndef TILED_BLOCK_CACHE_CONTROLLER_ASSERT_SVH
`define TILED_BLOCK_CACHE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define TBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tbc_pkg.sv
// shared types and constants of the tiled block cache controller
// no dependencies
package tbc_pkg;

	localparam int SLOTS             = 256;
	localparam int SLOT_W            = 8;
	localparam int TILE_BITS         = 5;
	localparam int OFFS_W            = 2 * TILE_BITS;
	localparam int TAG_W             = 20;
	localparam int ADDR_W            = 20;
	localparam int AGE_W             = 9;
	localparam int COORD_W           = 15;
	localparam int DIRECT_LIMIT_BITS = 10;
	localparam int ROW_BITS_MIN      = 4;

	localparam logic [AGE_W-1:0] AGE_CAP  = AGE_W'(2 * SLOTS - 1);
	localparam logic [AGE_W-1:0] AGE_STOP = AGE_W'(SLOTS - 1);
	localparam logic [3:0]       ARRAY_BITS_RESET = 4'd10;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [7:0]         write_byte;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] mem_address;
		logic              store_enable;
		logic [7:0]        store_byte;
		logic              hit;
		logic [SLOT_W-1:0] slot_used;
		logic              writeback_needed;
		logic [TAG_W-1:0]  writeback_tile;
		logic              fill_needed;
		logic [TAG_W-1:0]  fill_tile;
	} rsp_t;

	typedef struct packed {
		logic              direct;
		logic [ADDR_W-1:0] direct_addr;
		logic [TAG_W-1:0]  tile;
		logic [OFFS_W-1:0] offset;
	} map_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

### hw/rtl/tiled_block_cache_controller.sv
// tiled block cache controller: direct mode gives its result in the cycle after start
// tiled hit on slot i: the scan reads slots 0 up to i, busy until the result
// tiled miss: one tag/age scan then one age read-modify-write sweep
// one item at a time; the two single-port-read memory sweeps set the rate
// reset (and any array_bits write) clears slot valid flags, ages read as reset values
// array_bits resets to 10; the result strobe cannot be held off by the receiver
module tiled_block_cache_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tbc_pkg::cmd_t   cmd,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_wdata,
	output logic            done,
	output tbc_pkg::rsp_t   rsp
);
	import tbc_pkg::*;

	state_t state_q, state_d;

	logic [3:0]       array_bits_q;
	logic [SLOTS-1:0] slot_valid_q;
	logic             ages_written_q;

	map_t map_now, map_q;
	cmd_t cmd_q;

	logic [SLOT_W:0]   rd_idx_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic [TAG_W:0]   tag_rd;
	logic [AGE_W-1:0] age_rd;

	logic              tag_we, age_we;
	logic [SLOT_W-1:0] tag_waddr;
	logic [TAG_W:0]    tag_wdata;
	logic [AGE_W-1:0]  age_wdata;

	logic [AGE_W-1:0]  best_q;
	logic              stop_q;
	logic [SLOT_W-1:0] victim_q;
	logic [TAG_W-1:0]  victim_tag_q;
	logic              victim_dirty_q;

	logic              done_q;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_load;

	logic accept, issue, chk, match, last_s1, scan_miss_end, upd, upd_end, take;
	logic [AGE_W-1:0] age_cur, age_inc;

	tbc_coord_map u_map (
		.bits (array_bits_q),
		.x    (cmd.x_coord),
		.y    (cmd.y_coord),
		.map  (map_now)
	);

	// tag word: dirty bit on top of the tile number
	tbc_ram #(.WIDTH(TAG_W + 1), .DEPTH(SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (rd_idx_q[SLOT_W-1:0]),
		.rdata (tag_rd)
	);

	tbc_ram #(.WIDTH(AGE_W), .DEPTH(SLOTS)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (idx_s1),
		.wdata (age_wdata),
		.raddr (rd_idx_q[SLOT_W-1:0]),
		.rdata (age_rd)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign issue  = (state_q != ST_IDLE) && !rd_idx_q[SLOT_W];

	assign last_s1       = (idx_s1 == SLOT_W'(SLOTS - 1));
	assign chk           = (state_q == ST_SCAN) && vld_s1;
	assign match         = chk && slot_valid_q[idx_s1] && (tag_rd[TAG_W-1:0] == map_q.tile);
	assign scan_miss_end = chk && !match && last_s1;
	assign upd           = (state_q == ST_UPDATE) && vld_s1;
	assign upd_end       = upd && last_s1;

	// every update sweep writes all ages, so until the first full one they read as reset values
	assign age_cur = ages_written_q ? age_rd
		: AGE_W'((AGE_W + 1)'(SLOTS) - (AGE_W + 1)'(idx_s1));
	assign age_inc = (age_cur == AGE_CAP) ? age_cur : age_cur + AGE_W'(1);
	// slot 0 is the fallback victim, so its info is always captured
	assign take = (idx_s1 == '0) || (!stop_q && (age_cur > best_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !map_now.direct) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (match) state_d = ST_IDLE;
				else if (scan_miss_end) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (upd_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = idx_s1;
		tag_wdata = {1'b1, map_q.tile};
		age_we    = upd;
		age_wdata = (idx_s1 == victim_q) ? '0 : age_inc;
		rsp_load  = 1'b0;

		rsp_d.mem_address      = map_now.direct_addr;
		rsp_d.store_enable     = cmd.func;
		rsp_d.store_byte       = cmd.func ? cmd.write_byte : 8'd0;
		rsp_d.hit              = 1'b1;
		rsp_d.slot_used        = '0;
		rsp_d.writeback_needed = 1'b0;
		rsp_d.writeback_tile   = '0;
		rsp_d.fill_needed      = 1'b0;
		rsp_d.fill_tile        = '0;

		unique case (state_q)
			ST_IDLE: begin
				rsp_load = accept && map_now.direct;
			end
			ST_SCAN: begin
				rsp_d.store_enable = cmd_q.func;
				rsp_d.store_byte   = cmd_q.func ? cmd_q.write_byte : 8'd0;
				rsp_d.mem_address  = ADDR_W'({idx_s1, map_q.offset});
				rsp_d.slot_used    = idx_s1;
				if (match) begin
					rsp_load = 1'b1;
					tag_we   = cmd_q.func;
				end
			end
			ST_UPDATE: begin
				rsp_d.store_enable     = cmd_q.func;
				rsp_d.store_byte       = cmd_q.func ? cmd_q.write_byte : 8'd0;
				rsp_d.mem_address      = ADDR_W'({victim_q, map_q.offset});
				rsp_d.hit              = 1'b0;
				rsp_d.slot_used        = victim_q;
				rsp_d.writeback_needed = victim_dirty_q;
				rsp_d.writeback_tile   = victim_dirty_q ? victim_tag_q : '0;
				rsp_d.fill_needed      = 1'b1;
				rsp_d.fill_tile        = map_q.tile;
				if (upd_end) begin
					rsp_load  = 1'b1;
					tag_we    = 1'b1;
					tag_waddr = victim_q;
					tag_wdata = {cmd_q.func, map_q.tile};
				end
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			array_bits_q   <= ARRAY_BITS_RESET;
			slot_valid_q   <= '0;
			ages_written_q <= 1'b0;
			rd_idx_q       <= '0;
			vld_s1         <= 1'b0;
			done_q         <= 1'b0;
			stop_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			done_q  <= rsp_load;
			if (cfg_we) begin
				array_bits_q   <= cfg_wdata;
				slot_valid_q   <= '0;
				ages_written_q <= 1'b0;
			end else begin
				if (upd_end) ages_written_q <= 1'b1;
				if (upd_end) slot_valid_q[victim_q] <= 1'b1;
			end
			if (accept || scan_miss_end) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + (SLOT_W + 1)'(1);
			end
			if (accept) begin
				stop_q <= 1'b0;
			end else if (chk && take) begin
				stop_q <= (age_cur == AGE_STOP);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[SLOT_W-1:0];
		if (accept) begin
			cmd_q  <= cmd;
			map_q  <= map_now;
			best_q <= '0;
		end else if (chk && take) begin
			best_q         <= age_cur;
			victim_q       <= idx_s1;
			victim_tag_q   <= tag_rd[TAG_W-1:0];
			victim_dirty_q <= slot_valid_q[idx_s1] && tag_rd[TAG_W];
		end
		if (rsp_load) rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### hw/rtl/tbc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/tbc_coord_map.sv
// maps pixel coordinates to a direct address or a tile number and offset
// depends on tbc_pkg
module tbc_coord_map (
	input  logic [3:0]                  bits,
	input  logic [tbc_pkg::COORD_W-1:0] x,
	input  logic [tbc_pkg::COORD_W-1:0] y,
	output tbc_pkg::map_t               map
);
	import tbc_pkg::*;

	logic [COORD_W-1:0] lim;
	logic [COORD_W-1:0] xc, yc, xm, ym;
	logic [3:0]         rb;
	logic [3:0]         tshift;
	logic [25:0]        daddr;
	logic [29:0]        tile_hi;

	always_comb begin
		lim = COORD_W'((16'd1 << bits) - 16'd1);
		xc  = (x > lim) ? lim : x;
		yc  = (y > lim) ? lim : y;
		rb  = (bits < 4'(ROW_BITS_MIN)) ? 4'(ROW_BITS_MIN) : bits;
		// yc stays below 2^10 in direct mode, so this cannot spill past 20 bits
		daddr = (26'(yc) << rb) + 26'(xc);

		xm      = x & lim;
		ym      = y & lim;
		tshift  = bits - 4'(TILE_BITS);
		tile_hi = 30'(ym >> TILE_BITS) << tshift;

		map.direct      = (bits <= 4'(DIRECT_LIMIT_BITS));
		map.direct_addr = ADDR_W'(daddr);
		map.tile        = TAG_W'(tile_hi) | TAG_W'(xm >> TILE_BITS);
		map.offset      = {ym[TILE_BITS-1:0], xm[TILE_BITS-1:0]};
	end

endmodule

### hw/rtl/tbc_checker.sv
// port-level checks of the tiled block cache controller, bound to the top level
// depends on tbc_pkg and tiled_block_cache_controller_assert.svh
`include "tiled_block_cache_controller_assert.svh"

module tbc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input tbc_pkg::rsp_t rsp
);
	import tbc_pkg::*;

	// an item either finishes right away or keeps the block busy
	`TBC_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted item lost")
	`TBC_ASSERT_NOW(a_hit_no_traffic, done && rsp.hit, !rsp.fill_needed && !rsp.writeback_needed, "hit with transfer")
	`TBC_ASSERT_NOW(a_miss_fills, done && !rsp.hit, rsp.fill_needed, "miss without fill")
	`TBC_ASSERT_NOW(a_wb_tile_zero, done && !rsp.writeback_needed, rsp.writeback_tile == '0, "stray writeback tile")
	`TBC_ASSERT_NOW(a_read_no_byte, done && !rsp.store_enable, rsp.store_byte == 8'd0, "read with store byte")

endmodule

bind tiled_block_cache_controller tbc_checker u_tbc_checker (.*);
